// ===== design/ccksb_pkg.sv =====
// ----------------------------------------------------------------------------
// ccksb_pkg
// Shared types and constants of the colour-keyed sprite blitter: register
// indexes, draw modes, the configuration record and the recolouring function.
// ----------------------------------------------------------------------------
package ccksb_pkg;

   typedef enum logic [2:0] {
      REG_POS_X         = 3'd0,
      REG_POS_Y         = 3'd1,
      REG_SPRITE_WIDTH  = 3'd2,
      REG_SPRITE_HEIGHT = 3'd3,
      REG_TARGET_WIDTH  = 3'd4,
      REG_TARGET_HEIGHT = 3'd5,
      REG_DRAW_MODE     = 3'd6,
      REG_TINT_COLOR    = 3'd7
   } reg_index_type;

   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_FONT   = 2'd1;
   localparam logic [1:0] MODE_DAMAGE = 2'd2;

   localparam logic [31:0] FONT_WHITE = 32'h00ff_ffff;

   localparam int PAL_N = 7;
   localparam logic [31:0] PAL_FROM [PAL_N] = '{
      32'h0001_0101, 32'h0021_4942, 32'h0006_926b, 32'h006b_6e6b,
      32'h00d2_b48c, 32'h0041_4841, 32'h008b_6d41
   };
   localparam logic [31:0] PAL_TO [PAL_N] = '{
      32'h0099_0000, 32'h00dd_3333, 32'h00dd_5555, 32'h00ff_4444,
      32'h00ff_3333, 32'h00b2_2222, 32'h00dc_143c
   };

   typedef struct packed {
      logic signed [12:0] pos_x;
      logic signed [12:0] pos_y;
      logic [10:0]        sprite_width;
      logic [10:0]        sprite_height;
      logic [12:0]        target_width;
      logic [12:0]        target_height;
      logic [1:0]         draw_mode;
      logic [31:0]        tint_color;
   } cfg_type;

   function automatic logic [31:0] recolour(input logic [31:0] c,
                                            input logic [1:0]  mode,
                                            input logic [31:0] tint);
      logic [31:0] r;
      r = c;
      case (mode)
         MODE_FONT: begin
            if (c == FONT_WHITE) r = tint;
         end
         MODE_DAMAGE: begin
            // swaps are tried in turn, each on the running value
            for (int i = 0; i < PAL_N; i++) begin
               if (r == PAL_FROM[i]) r = PAL_TO[i];
            end
         end
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

// ===== design/ccksb_if.sv =====
// ----------------------------------------------------------------------------
// ccksb_if
// Handshake channels of the blitter: source pixel words in, write words out.
// ----------------------------------------------------------------------------
interface ccksb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_color;

   modport source (output valid, output pixel_color, input ready);
   modport sink (input valid, input pixel_color, output ready);
endinterface

interface ccksb_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] write_address;
   logic [31:0] write_color;

   modport source (output valid, output write_address, output write_color, input ready);
   modport sink (input valid, input write_address, input write_color, output ready);
endinterface

// ===== design/clipped_color_key_sprite_blit.sv =====
// ----------------------------------------------------------------------------
// clipped_color_key_sprite_blit
// Takes one sprite pixel word per clock in raster order, unless rsp holds
// back the flow, and gives one write word (target address, colour) for every
// pixel that lands on the target surface and is not transparent after
// recolouring. Throughput is one pixel per cycle while rsp takes each word;
// a pixel passes through the input register (counters, recolouring) and then
// the result register (clipping, row-times-stride multiply). Clipped and
// transparent pixels give no word. A result waiting on rsp does not stop req
// while the input register can still move on. Write configuration only while idle.
// ----------------------------------------------------------------------------
module clipped_color_key_sprite_blit #(
   parameter int MAX_SPRITE_DIM = 1024
) (
   input  logic        clock,
   input  logic        reset,
   ccksb_req_if.sink   req,
   ccksb_rsp_if.source rsp,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import ccksb_pkg::*;

   localparam int CNT_W = $clog2(MAX_SPRITE_DIM);
   localparam int TX_W  = ((CNT_W + 1 > 13) ? CNT_W + 1 : 13) + 1;

   cfg_type                cfg;
   logic                   s1_valid, s1_take;
   logic [31:0]            s1_color;
   logic signed [TX_W-1:0] s1_tx, s1_ty;

   ccksb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ccksb_front #(.MAX_SPRITE_DIM(MAX_SPRITE_DIM)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req),
      .s1_take  (s1_take),
      .s1_valid (s1_valid),
      .s1_color (s1_color),
      .s1_tx    (s1_tx),
      .s1_ty    (s1_ty)
   );

   ccksb_back #(.TX_W(TX_W)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid),
      .s1_color (s1_color),
      .s1_tx    (s1_tx),
      .s1_ty    (s1_ty),
      .s1_take  (s1_take),
      .rsp      (rsp)
   );

endmodule

// ===== design/ccksb_csr.sv =====
// ----------------------------------------------------------------------------
// ccksb_csr
// Configuration registers, written through a plain index/data write port.
// ----------------------------------------------------------------------------
module ccksb_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   output ccksb_pkg::cfg_type cfg
);
   import ccksb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_POS_X:         cfg_in.pos_x         = $signed(csr_write_data[12:0]);
            REG_POS_Y:         cfg_in.pos_y         = $signed(csr_write_data[12:0]);
            REG_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_write_data[10:0];
            REG_SPRITE_HEIGHT: cfg_in.sprite_height = csr_write_data[10:0];
            REG_TARGET_WIDTH:  cfg_in.target_width  = csr_write_data[12:0];
            REG_TARGET_HEIGHT: cfg_in.target_height = csr_write_data[12:0];
            REG_DRAW_MODE:     cfg_in.draw_mode     = csr_write_data[1:0];
            REG_TINT_COLOR:    cfg_in.tint_color    = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x         <= '0;
         cfg_ff.pos_y         <= '0;
         cfg_ff.sprite_width  <= 11'd1;
         cfg_ff.sprite_height <= 11'd1;
         cfg_ff.target_width  <= 13'd1;
         cfg_ff.target_height <= 13'd1;
         cfg_ff.draw_mode     <= MODE_PLAIN;
         cfg_ff.tint_color    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/ccksb_front.sv =====
// ----------------------------------------------------------------------------
// ccksb_front
// Input stage: frame column/row counters, target coordinates and
// recolouring, held in the input register.
// ----------------------------------------------------------------------------
module ccksb_front #(
   parameter int  MAX_SPRITE_DIM = 1024,
   localparam int CNT_W = $clog2(MAX_SPRITE_DIM),
   localparam int TX_W  = ((CNT_W + 1 > 13) ? CNT_W + 1 : 13) + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ccksb_pkg::cfg_type     cfg,
   ccksb_req_if.sink              req,
   input  logic                   s1_take,
   output logic                   s1_valid,
   output logic [31:0]            s1_color,
   output logic signed [TX_W-1:0] s1_tx,
   output logic signed [TX_W-1:0] s1_ty
);
   import ccksb_pkg::*;

   localparam int DIM_W = ($clog2(MAX_SPRITE_DIM + 1) > 11) ?
                          $clog2(MAX_SPRITE_DIM + 1) : 11;
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_SPRITE_DIM);

   logic [CNT_W-1:0]       col_ff, col_in, row_ff, row_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic [31:0]            s1_color_ff;
   logic signed [TX_W-1:0] s1_tx_ff, s1_ty_ff;
   logic                   accept;
   logic [DIM_W-1:0]       eff_w, eff_h, col_next, row_next;
   logic [DIM_W-1:0]       w_ext, h_ext;

   assign req.ready = !s1_valid_ff || s1_take;
   assign accept    = req.valid && req.ready;

   assign w_ext = DIM_W'(cfg.sprite_width);
   assign h_ext = DIM_W'(cfg.sprite_height);

   // zero size acts as one, oversize clamps to the largest frame
   always_comb begin
      if (w_ext == '0)         eff_w = DIM_W'(1);
      else if (w_ext > DIM_MAX) eff_w = DIM_MAX;
      else                     eff_w = w_ext;
      if (h_ext == '0)         eff_h = DIM_W'(1);
      else if (h_ext > DIM_MAX) eff_h = DIM_MAX;
      else                     eff_h = h_ext;
   end

   assign col_next = DIM_W'(col_ff) + DIM_W'(1);
   assign row_next = DIM_W'(row_ff) + DIM_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= eff_w) begin
            col_in = '0;
            if (row_next >= eff_h) row_in = '0;
            else                   row_in = row_next[CNT_W-1:0];
         end else begin
            col_in = col_next[CNT_W-1:0];
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_color_ff <= recolour(req.pixel_color, cfg.draw_mode, cfg.tint_color);
         s1_tx_ff    <= TX_W'(cfg.pos_x) + TX_W'($signed({1'b0, col_ff}));
         s1_ty_ff    <= TX_W'(cfg.pos_y) + TX_W'($signed({1'b0, row_ff}));
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_color = s1_color_ff;
   assign s1_tx    = s1_tx_ff;
   assign s1_ty    = s1_ty_ff;

endmodule

// ===== design/ccksb_back.sv =====
// ----------------------------------------------------------------------------
// ccksb_back
// Output stage: clip against the target surface, drop transparent pixels,
// form the write address and hold the write word for the sink.
// ----------------------------------------------------------------------------
module ccksb_back #(
   parameter int TX_W = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ccksb_pkg::cfg_type     cfg,
   input  logic                   s1_valid,
   input  logic [31:0]            s1_color,
   input  logic signed [TX_W-1:0] s1_tx,
   input  logic signed [TX_W-1:0] s1_ty,
   output logic                   s1_take,
   ccksb_rsp_if.source            rsp
);
   import ccksb_pkg::*;

   logic        hit;
   logic [25:0] row_base;
   logic [23:0] addr_in, addr_ff;
   logic [31:0] color_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   // coordinates are non-negative once the sign bit is clear
   assign hit = !s1_tx[TX_W-1] && !s1_ty[TX_W-1]
             && ($unsigned(s1_tx) < TX_W'(cfg.target_width))
             && ($unsigned(s1_ty) < TX_W'(cfg.target_height))
             && (s1_color[23:0] != 24'd0);

   assign row_base = s1_ty[12:0] * cfg.target_width;
   assign addr_in  = row_base[23:0] + 24'(s1_tx[12:0]);

   assign s1_take      = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = s1_take ? (s1_valid && hit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take && s1_valid && hit) begin
         addr_ff  <= addr_in;
         color_ff <= s1_color;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.write_address = addr_ff;
   assign rsp.write_color   = color_ff;

endmodule
